FILE: hdl/assert_macros.svh
// Assertion helpers included by the encoder core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hdl/rspe_pkg.sv
package rspe_pkg;

    // Action codes of an input word.
    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_UNIT  = 2'd1;
    localparam logic [1:0] ACT_GROUP = 2'd2;
    localparam logic [1:0] ACT_DIM   = 2'd3;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] REG_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT  = 2'd2;

    // Bit position counter covers up to 32 address bits.
    localparam int unsigned POS_W    = 5;
    localparam int unsigned FRAMES_W = 7;
    localparam int unsigned REPEAT_W = 3;

    // Multipliers of the base period.
    localparam int unsigned START_LOW_MULT = 10;
    localparam int unsigned BIT_LONG_MULT  = 5;
    localparam int unsigned STOP_LOW_MULT  = 40;

endpackage

FILE: hdl/remote_switch_pulse_encoder_core.sv
// On-off pulse train encoder for a 433 MHz remote switch.
//
// Input channel (in_valid / in_stall) carries one word per cycle while in_stall is low: either a
// one-microsecond tick or a send command (unit, group or dim). A command is
// taken only while the encoder is idle; otherwise it is dropped with
// command_taken low and does not count as a tick. Every input word yields
// exactly one output word (pin_level, busy_res, command_taken) on the output
// channel (out_valid / out_stall).
// Configuration is written through cfg_valid / cfg_ready / cfg_index /
// cfg_data, one register per write, always ready; write only while idle.
//
// An accepted word is captured in the input register, and the segment logic
// result then lands in the output register once the output slot is free.
// Throughput is one word per cycle while the receiver does not stall.
// When the receiver stalls, the output register holds its word, the input
// register fills, and in_stall rises until the output word is taken.
// Reset clears both pipeline registers, puts the encoder idle with the pin
// low, and restores the register defaults (address 0, period 250, 8 frames).
`include "assert_macros.svh"

module remote_switch_pulse_encoder_core #(
    parameter int unsigned ADDRESS_BITS = 26,
    parameter int unsigned PERIOD_BITS  = 12
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Configuration write port
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [rspe_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rspe_pkg::CFG_DATA_W-1:0]    cfg_data,
    // Input channel
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [1:0]                         action,
    input  logic [3:0]                         unit,
    input  logic                               switch_on,
    input  logic [3:0]                         dim_level,
    // Output channel
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               pin_level,
    output logic                               busy_res,
    output logic                               command_taken
);

    localparam int unsigned TICK_W = PERIOD_BITS + 6;
    localparam int unsigned AIDX_W = (ADDRESS_BITS > 1) ? $clog2(ADDRESS_BITS) : 1;
    localparam logic [rspe_pkg::POS_W-1:0] ADDR_TOP = rspe_pkg::POS_W'(ADDRESS_BITS - 1);
    localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = PERIOD_BITS'(250);

    typedef enum logic [2:0] {
        F_IDLE   = 3'd0,
        F_START  = 3'd1,
        F_ADDR   = 3'd2,
        F_GROUP  = 3'd3,
        F_SWITCH = 3'd4,
        F_UNIT   = 3'd5,
        F_DIM    = 3'd6,
        F_STOP   = 3'd7
    } field_t;

    // Configuration registers
    logic [ADDRESS_BITS-1:0]           address_reg;
    logic [PERIOD_BITS-1:0]            period_reg;
    logic [rspe_pkg::REPEAT_W-1:0]     repeat_reg;

    // Input register
    logic                              in_valid_reg;
    logic [1:0]                        action_reg;
    logic [3:0]                        unit_reg;
    logic                              switch_reg;
    logic [3:0]                        dim_reg;

    // Encoder state
    logic                              level_reg,   level_next;
    field_t                            field_reg,   field_next;
    logic [rspe_pkg::POS_W-1:0]        pos_reg,     pos_next;
    logic [1:0]                        step_reg,    step_next;
    logic [TICK_W-1:0]                 ticks_reg,   ticks_next;
    logic [rspe_pkg::FRAMES_W-1:0]     frames_reg,  frames_next;
    logic [1:0]                        kind_reg,    kind_next;
    logic [3:0]                        hunit_reg,   hunit_next;
    logic                              hswitch_reg, hswitch_next;
    logic [3:0]                        hdim_reg,    hdim_next;

    // Output register
    logic                              out_valid_reg;
    logic                              pin_reg;
    logic                              busy_reg;
    logic                              taken_reg;

    logic                              proc_fire;
    logic                              in_fire;
    logic                              taken_next;
    logic                              load_seg;
    logic                              seg_bit;
    logic [TICK_W-1:0]                 t_one;
    logic [TICK_W-1:0]                 t_five;
    logic [TICK_W-1:0]                 t_start;
    logic [TICK_W-1:0]                 t_stop;
    logic [TICK_W-1:0]                 seg_len;

    // Handshakes: the input register drains whenever the output slot is free.
    assign proc_fire = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !proc_fire;
    assign in_fire   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    assign out_valid     = out_valid_reg;
    assign pin_level     = pin_reg;
    assign busy_res      = busy_reg;
    assign command_taken = taken_reg;

    // Period multiples; a zero period counts as one tick.
    always_comb
    begin
        t_one   = (period_reg == '0) ? TICK_W'(1) : TICK_W'(period_reg);
        t_five  = (t_one << 2) + t_one;
        t_start = (t_one << 3) + (t_one << 1) + (t_one >> 1);
        t_stop  = (t_one << 5) + (t_one << 3);
    end

    // Next encoder state for the word in the input register.
    always_comb
    begin
        level_next   = level_reg;
        field_next   = field_reg;
        pos_next     = pos_reg;
        step_next    = step_reg;
        ticks_next   = ticks_reg;
        frames_next  = frames_reg;
        kind_next    = kind_reg;
        hunit_next   = hunit_reg;
        hswitch_next = hswitch_reg;
        hdim_next    = hdim_reg;
        taken_next   = 1'b0;
        load_seg     = 1'b0;

        if (proc_fire)
        begin
            if (action_reg == rspe_pkg::ACT_TICK)
            begin
                if (field_reg != F_IDLE)
                begin
                    if (ticks_reg > TICK_W'(1))
                    begin
                        ticks_next = ticks_reg - TICK_W'(1);
                    end
                    else if (((field_reg == F_START || field_reg == F_STOP) && step_reg != 2'd1)
                             || (field_reg != F_START && field_reg != F_STOP
                                 && step_reg != 2'd3))
                    begin
                        // Next segment of the same symbol.
                        step_next = step_reg + 2'd1;
                        load_seg  = 1'b1;
                    end
                    else
                    begin
                        step_next = 2'd0;
                        load_seg  = 1'b1;
                        if ((field_reg == F_ADDR || field_reg == F_UNIT || field_reg == F_DIM)
                            && pos_reg != '0)
                        begin
                            pos_next = pos_reg - rspe_pkg::POS_W'(1);
                        end
                        else
                        begin
                            unique case (field_reg)
                                F_START:
                                begin
                                    field_next = F_ADDR;
                                    pos_next   = ADDR_TOP;
                                end
                                F_ADDR:
                                begin
                                    field_next = F_GROUP;
                                    pos_next   = '0;
                                end
                                F_GROUP:
                                begin
                                    field_next = F_SWITCH;
                                end
                                F_SWITCH:
                                begin
                                    field_next = F_UNIT;
                                    pos_next   = rspe_pkg::POS_W'(3);
                                end
                                F_UNIT:
                                begin
                                    if (kind_reg == rspe_pkg::ACT_DIM)
                                    begin
                                        field_next = F_DIM;
                                        pos_next   = rspe_pkg::POS_W'(3);
                                    end
                                    else
                                    begin
                                        field_next = F_STOP;
                                        pos_next   = '0;
                                    end
                                end
                                F_DIM:
                                begin
                                    field_next = F_STOP;
                                    pos_next   = '0;
                                end
                                default:
                                begin
                                    // End of a stop pulse: repeat or go idle.
                                    pos_next = '0;
                                    if (frames_reg != '0)
                                    begin
                                        frames_next = frames_reg - rspe_pkg::FRAMES_W'(1);
                                        field_next  = F_START;
                                    end
                                    else
                                    begin
                                        field_next = F_IDLE;
                                        ticks_next = '0;
                                        level_next = 1'b0;
                                        load_seg   = 1'b0;
                                    end
                                end
                            endcase
                        end
                    end
                end
            end
            else if (field_reg == F_IDLE)
            begin
                // Latch the command and start the first frame.
                taken_next   = 1'b1;
                kind_next    = action_reg;
                hunit_next   = (action_reg == rspe_pkg::ACT_GROUP) ? 4'd0 : unit_reg;
                hswitch_next = (action_reg == rspe_pkg::ACT_DIM) ? 1'b0 : switch_reg;
                hdim_next    = dim_reg;
                frames_next  = (rspe_pkg::FRAMES_W'(1) << repeat_reg)
                               - rspe_pkg::FRAMES_W'(1);
                field_next   = F_START;
                pos_next     = '0;
                step_next    = 2'd0;
                load_seg     = 1'b1;
            end
        end

        // Data bit of the segment being loaded.
        unique case (field_next)
            F_ADDR:   seg_bit = address_reg[pos_next[AIDX_W-1:0]];
            F_GROUP:  seg_bit = (kind_next == rspe_pkg::ACT_GROUP);
            F_SWITCH: seg_bit = hswitch_next;
            F_UNIT:   seg_bit = hunit_next[pos_next[1:0]];
            F_DIM:    seg_bit = hdim_next[pos_next[1:0]];
            default:  seg_bit = 1'b0;
        endcase

        // Length of the segment being loaded.
        if (field_next == F_START)
        begin
            seg_len = (step_next == 2'd0) ? t_one : t_start;
        end
        else if (field_next == F_STOP)
        begin
            seg_len = (step_next == 2'd0) ? t_one : t_stop;
        end
        else if (field_next == F_SWITCH && kind_next == rspe_pkg::ACT_DIM)
        begin
            seg_len = t_one;
        end
        else if (step_next == 2'd1)
        begin
            seg_len = seg_bit ? t_five : t_one;
        end
        else if (step_next == 2'd3)
        begin
            seg_len = seg_bit ? t_one : t_five;
        end
        else
        begin
            seg_len = t_one;
        end

        if (load_seg)
        begin
            level_next = !step_next[0];
            ticks_next = seg_len;
        end
    end

    // Registers: configuration, input stage, encoder state and output stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            address_reg   <= '0;
            period_reg    <= PERIOD_RESET;
            repeat_reg    <= rspe_pkg::REPEAT_W'(3);
            in_valid_reg  <= 1'b0;
            level_reg     <= 1'b0;
            field_reg     <= F_IDLE;
            pos_reg       <= '0;
            step_reg      <= 2'd0;
            ticks_reg     <= '0;
            frames_reg    <= '0;
            kind_reg      <= 2'd0;
            hunit_reg     <= 4'd0;
            hswitch_reg   <= 1'b0;
            hdim_reg      <= 4'd0;
            out_valid_reg <= 1'b0;
            pin_reg       <= 1'b0;
            busy_reg      <= 1'b0;
            taken_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    rspe_pkg::REG_ADDRESS: address_reg <= cfg_data[ADDRESS_BITS-1:0];
                    rspe_pkg::REG_PERIOD:  period_reg  <= cfg_data[PERIOD_BITS-1:0];
                    rspe_pkg::REG_REPEAT:  repeat_reg  <= cfg_data[rspe_pkg::REPEAT_W-1:0];
                    default:               ;
                endcase
            end

            if (in_fire)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (proc_fire)
            begin
                in_valid_reg <= 1'b0;
            end

            level_reg   <= level_next;
            field_reg   <= field_next;
            pos_reg     <= pos_next;
            step_reg    <= step_next;
            ticks_reg   <= ticks_next;
            frames_reg  <= frames_next;
            kind_reg    <= kind_next;
            hunit_reg   <= hunit_next;
            hswitch_reg <= hswitch_next;
            hdim_reg    <= hdim_next;

            if (proc_fire)
            begin
                out_valid_reg <= 1'b1;
                pin_reg       <= level_next;
                busy_reg      <= (field_next != F_IDLE);
                taken_reg     <= taken_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Input payload registers without reset.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            action_reg <= action;
            unit_reg   <= unit;
            switch_reg <= switch_on;
            dim_reg    <= dim_level;
        end
    end

    // The pin is low whenever no frame is in progress.
    `ASSERT_IMPLIES(a_idle_pin_low, clk, rst_n, field_reg == F_IDLE, !level_reg)
    // An accepted command always leaves the encoder busy.
    `ASSERT_IMPLIES(a_taken_busy, clk, rst_n, out_valid_reg && taken_reg, busy_reg)
    // Back-pressure only arises from a full input stage behind a stalled output.
    `ASSERT_IMPLIES(a_stall_cause, clk, rst_n, in_stall, in_valid_reg && out_valid_reg && out_stall)
    // A processed word always shows up in the output stage next cycle.
    `ASSERT_NEXT(a_proc_out, clk, rst_n, proc_fire, out_valid_reg)

endmodule

FILE: tb/remote_switch_pulse_encoder_core_test.sv
module remote_switch_pulse_encoder_core_test;

    localparam int unsigned ADDRESS_BITS = 26;
    localparam int unsigned PERIOD_BITS  = 12;
    localparam int CLK_PERIOD    = 12;
    localparam int RESET_CYCLES  = 12;
    localparam int RANDOM_ITEMS  = 300;
    localparam int LONG_HOLD     = 60;
    localparam int DRAIN_CYCLES  = 8;
    localparam int CYCLE_LIMIT   = 2000000;
    localparam int SCRIPT_ROWS   = 11;

    // Index that decodes to no register.
    localparam logic [rspe_pkg::CFG_IDX_W-1:0] REG_NONE = 2'd3;

    typedef struct packed {
        logic pin;
        logic busy;
        logic taken;
    } encoder_word_t;

    typedef enum logic [2:0] {
        PART_IDLE, PART_START, PART_ADDRESS, PART_GROUP,
        PART_SWITCH, PART_UNIT, PART_DIM, PART_STOP
    } frame_part_t;

    typedef enum logic [1:0] {ROW_WORD, ROW_REG, ROW_FLUSH} row_kind_t;

    typedef struct packed {
        row_kind_t     kind;
        logic [1:0]    sel;
        logic [31:0]   data;
        logic [3:0]    unt;
        logic          sw;
        logic [3:0]    lvl;
        logic          typed;
        encoder_word_t want;
    } script_row_t;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [rspe_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [rspe_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                            in_valid;
    logic                            in_stall;
    logic [1:0]                      action;
    logic [3:0]                      unit;
    logic                            switch_on;
    logic [3:0]                      dim_level;
    logic                            out_valid;
    logic                            out_stall;
    logic                            pin_level;
    logic                            busy_res;
    logic                            command_taken;

    // Shadow of the encoder: registers and transmit state.
    logic [ADDRESS_BITS-1:0] reg_address = '0;
    logic [PERIOD_BITS-1:0]  reg_period  = 12'd250;
    logic [2:0]              reg_repeat  = 3'd3;
    logic                    line_level   = 1'b0;
    frame_part_t             part         = PART_IDLE;
    logic [4:0]              bit_idx      = '0;
    logic [1:0]              seg_idx      = '0;
    logic [17:0]             seg_left     = '0;
    logic [6:0]              frames_to_go = '0;
    logic [1:0]              cmd_kind     = '0;
    logic [3:0]              cmd_unit     = '0;
    logic                    cmd_switch   = 1'b0;
    logic [3:0]              cmd_dim      = '0;

    encoder_word_t awaited_words[$];
    script_row_t   script [SCRIPT_ROWS];

    int  error_count    = 0;
    int  words_checked  = 0;
    int  live_items     = 0;
    int  ignored_items  = 0;
    int  commands_taken = 0;
    int  cycle_count    = 0;
    bit  idling_on      = 1'b1;
    bit  long_hold_req  = 1'b0;
    bit  word_seen      = 1'b0;

    remote_switch_pulse_encoder_core #(
        .ADDRESS_BITS (ADDRESS_BITS),
        .PERIOD_BITS  (PERIOD_BITS)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .unit          (unit),
        .switch_on     (switch_on),
        .dim_level     (dim_level),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .pin_level     (pin_level),
        .busy_res      (busy_res),
        .command_taken (command_taken)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Level and length of the segment selected by part, bit and step.
    function automatic void enter_segment();
        int t;
        logic b;
        t = (reg_period == '0) ? 1 : int'(reg_period);
        line_level = ~seg_idx[0];
        case (part)
            PART_ADDRESS: b = reg_address[bit_idx];
            PART_GROUP:   b = (cmd_kind == rspe_pkg::ACT_GROUP);
            PART_SWITCH:  b = cmd_switch;
            PART_UNIT:    b = cmd_unit[bit_idx[1:0]];
            PART_DIM:     b = cmd_dim[bit_idx[1:0]];
            default:      b = 1'b0;
        endcase
        if (part == PART_START)
            seg_left = 18'((seg_idx == 2'd0) ? t : t * rspe_pkg::START_LOW_MULT + t / 2);
        else if (part == PART_STOP)
            seg_left = 18'((seg_idx == 2'd0) ? t : t * rspe_pkg::STOP_LOW_MULT);
        else if (part == PART_SWITCH && cmd_kind == rspe_pkg::ACT_DIM)
            seg_left = 18'(t);
        else if (seg_idx == 2'd1)
            seg_left = 18'(b ? t * rspe_pkg::BIT_LONG_MULT : t);
        else if (seg_idx == 2'd3)
            seg_left = 18'(b ? t : t * rspe_pkg::BIT_LONG_MULT);
        else
            seg_left = 18'(t);
    endfunction

    // One input word through the encoder; returns the word it puts out.
    function automatic void encoder_step(input logic [1:0] act, input logic [3:0] unt,
                                         input logic sw, input logic [3:0] lvl,
                                         output encoder_word_t w);
        int last_seg;
        w.taken = 1'b0;
        if (act == rspe_pkg::ACT_TICK)
        begin
            if (part != PART_IDLE)
            begin
                if (seg_left > 18'd1)
                    seg_left = seg_left - 18'd1;
                else
                begin
                    last_seg = (part == PART_START || part == PART_STOP) ? 1 : 3;
                    if (int'(seg_idx) < last_seg)
                    begin
                        seg_idx = seg_idx + 2'd1;
                        enter_segment();
                    end
                    else
                    begin
                        seg_idx = 2'd0;
                        if ((part == PART_ADDRESS || part == PART_UNIT || part == PART_DIM)
                            && bit_idx != 5'd0)
                        begin
                            bit_idx = bit_idx - 5'd1;
                            enter_segment();
                        end
                        else
                        begin
                            // Move on to the next field of the frame.
                            case (part)
                                PART_START:
                                begin
                                    part = PART_ADDRESS;
                                    bit_idx = 5'(ADDRESS_BITS - 1);
                                end
                                PART_ADDRESS:
                                begin
                                    part = PART_GROUP;
                                    bit_idx = 5'd0;
                                end
                                PART_GROUP:
                                    part = PART_SWITCH;
                                PART_SWITCH:
                                begin
                                    part = PART_UNIT;
                                    bit_idx = 5'd3;
                                end
                                PART_UNIT:
                                begin
                                    part = (cmd_kind == rspe_pkg::ACT_DIM) ? PART_DIM
                                                                          : PART_STOP;
                                    bit_idx = (cmd_kind == rspe_pkg::ACT_DIM) ? 5'd3 : 5'd0;
                                end
                                PART_DIM:
                                begin
                                    part = PART_STOP;
                                    bit_idx = 5'd0;
                                end
                                default:
                                begin
                                    // End of a stop pulse: repeat the frame or go idle.
                                    bit_idx = 5'd0;
                                    if (frames_to_go != 7'd0)
                                    begin
                                        frames_to_go = frames_to_go - 7'd1;
                                        part = PART_START;
                                    end
                                    else
                                    begin
                                        part = PART_IDLE;
                                        seg_left = '0;
                                        line_level = 1'b0;
                                    end
                                end
                            endcase
                            if (part != PART_IDLE)
                                enter_segment();
                        end
                    end
                end
            end
        end
        else if (part == PART_IDLE)
        begin
            // A command is latched only while idle.
            w.taken = 1'b1;
            cmd_kind = act;
            cmd_unit = (act == rspe_pkg::ACT_GROUP) ? 4'd0 : unt;
            cmd_switch = (act == rspe_pkg::ACT_DIM) ? 1'b0 : sw;
            cmd_dim = lvl;
            frames_to_go = 7'((32'd1 << reg_repeat) - 32'd1);
            part = PART_START;
            bit_idx = 5'd0;
            seg_idx = 2'd0;
            enter_segment();
        end
        w.pin = line_level;
        w.busy = (part != PART_IDLE);
    endfunction

    // Wait drawn before each word on either side.
    function automatic int draw_gap();
        if (!idling_on || $urandom_range(0, 3) != 0)
            return 0;
        return int'($urandom_range(0, 19));
    endfunction

    function automatic int field_check(input string name, input logic want, input logic got);
        if (got === want)
            return 0;
        $display("%0t: %s expected %0b, got %0b", $time, name, want, got);
        return 1;
    endfunction

    // Offer one input word, wait for it to be taken, and predict its output.
    task automatic send_word(input logic [1:0] act, input logic [3:0] unt, input logic sw,
                             input logic [3:0] lvl, input logic typed,
                             input encoder_word_t want);
        int gap;
        bit was_busy;
        encoder_word_t w;
        gap = draw_gap();
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        action    <= act;
        unit      <= unt;
        switch_on <= sw;
        dim_level <= lvl;
        do @(posedge clk); while (in_stall !== 1'b0);
        was_busy = (part != PART_IDLE);
        encoder_step(act, unt, sw, lvl, w);
        if (w.taken)
            commands_taken++;
        if (w.taken || (act == rspe_pkg::ACT_TICK && was_busy))
            live_items++;
        else
            ignored_items++;
        awaited_words.push_back(typed ? want : w);
    endtask

    task automatic send_tick();
        send_word(rspe_pkg::ACT_TICK, 4'($urandom()), 1'($urandom()), 4'($urandom()),
                  1'b0, 3'b000);
    endtask

    task automatic send_command();
        send_word(2'($urandom_range(1, 3)), 4'($urandom()), 1'($urandom()), 4'($urandom()),
                  1'b0, 3'b000);
    endtask

    // Tick until the transmission ends, with stray commands mixed in if asked.
    task automatic run_to_idle(input bit noisy);
        while (part != PART_IDLE)
        begin
            if (noisy && $urandom_range(0, 39) == 0)
                send_command();
            else
                send_tick();
        end
    endtask

    // Stop offering words and wait until every output word is back.
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (awaited_words.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [rspe_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] data);
        settle();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        case (idx)
            rspe_pkg::REG_ADDRESS: reg_address = data[ADDRESS_BITS-1:0];
            rspe_pkg::REG_PERIOD:  reg_period = data[PERIOD_BITS-1:0];
            rspe_pkg::REG_REPEAT:  reg_repeat = data[2:0];
            default:               ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Output side: compare each word taken with the oldest prediction.
    always @(posedge clk)
    begin : monitor
        encoder_word_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            word_seen = 1'b1;
            if (awaited_words.size() == 0)
            begin
                $display("%0t: unexpected word pin_level=%0b busy_res=%0b command_taken=%0b",
                         $time, pin_level, busy_res, command_taken);
                error_count++;
            end
            else
            begin
                want = awaited_words.pop_front();
                words_checked++;
                error_count += field_check("pin_level", want.pin, pin_level);
                error_count += field_check("busy_res", want.busy, busy_res);
                error_count += field_check("command_taken", want.taken, command_taken);
            end
        end
    end

    // Output stall: a random wait before each word, one long hold-off on request.
    initial
    begin : receiver
        int hold;
        hold = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                hold = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            else if (word_seen)
                hold = draw_gap();
            word_seen = 1'b0;
            out_stall <= (hold != 0);
            if (hold != 0)
                hold--;
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("remote_switch_pulse_encoder_core: mismatch");
        $finish;
    end

    initial
    begin : stimulus
        int mark;
        bit first;
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = rspe_pkg::REG_ADDRESS;
        cfg_data  = '0;
        in_valid  = 1'b0;
        action    = rspe_pkg::ACT_TICK;
        unit      = '0;
        switch_on = 1'b0;
        dim_level = '0;

        // Directed rows: reset state, register masking, zero period, busy commands.
        script[0]  = '{ROW_WORD,  rspe_pkg::ACT_TICK,    32'd0,         4'd0,  1'b0, 4'd0,
                       1'b1, 3'b000};
        script[1]  = '{ROW_REG,   rspe_pkg::REG_ADDRESS, 32'hFFFF_FFFF, 4'd0,  1'b0, 4'd0,
                       1'b0, 3'b000};
        script[2]  = '{ROW_REG,   rspe_pkg::REG_PERIOD,  32'hFFFF_F000, 4'd0,  1'b0, 4'd0,
                       1'b0, 3'b000};
        script[3]  = '{ROW_REG,   rspe_pkg::REG_REPEAT,  32'd0,         4'd0,  1'b0, 4'd0,
                       1'b0, 3'b000};
        script[4]  = '{ROW_REG,   REG_NONE,              32'd7,         4'd0,  1'b0, 4'd0,
                       1'b0, 3'b000};
        script[5]  = '{ROW_WORD,  rspe_pkg::ACT_DIM,     32'd0,         4'd15, 1'b1, 4'd15,
                       1'b1, 3'b111};
        script[6]  = '{ROW_WORD,  rspe_pkg::ACT_GROUP,   32'd0,         4'd3,  1'b0, 4'd9,
                       1'b1, 3'b110};
        script[7]  = '{ROW_WORD,  rspe_pkg::ACT_UNIT,    32'd0,         4'd0,  1'b1, 4'd0,
                       1'b1, 3'b110};
        script[8]  = '{ROW_WORD,  rspe_pkg::ACT_TICK,    32'd0,         4'd0,  1'b0, 4'd0,
                       1'b0, 3'b000};
        script[9]  = '{ROW_FLUSH, rspe_pkg::ACT_TICK,    32'd0,         4'd0,  1'b0, 4'd0,
                       1'b0, 3'b000};
        script[10] = '{ROW_WORD,  rspe_pkg::ACT_TICK,    32'd0,         4'd15, 1'b1, 4'd15,
                       1'b1, 3'b000};

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < SCRIPT_ROWS; r++)
        begin
            case (script[r].kind)
                ROW_REG:   write_reg(script[r].sel, script[r].data);
                ROW_WORD:  send_word(script[r].sel, script[r].unt, script[r].sw,
                                     script[r].lvl, script[r].typed, script[r].want);
                default:   run_to_idle(1'b0);
            endcase
        end

        // Random transmissions at short periods; the first one also gets a long
        // receiver hold-off so the pipeline backs up into the input.
        mark = live_items;
        first = 1'b1;
        while (live_items - mark < RANDOM_ITEMS)
        begin
            idling_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 1) == 0)
            begin
                write_reg(rspe_pkg::REG_ADDRESS, $urandom());
                write_reg(rspe_pkg::REG_PERIOD, 32'($urandom_range(0, 2)));
                write_reg(rspe_pkg::REG_REPEAT, 32'($urandom_range(0, 1)));
                if ($urandom_range(0, 3) == 0)
                    write_reg(REG_NONE, $urandom());
            end
            repeat ($urandom_range(0, 2)) send_tick();
            send_command();
            if (first)
            begin
                long_hold_req = 1'b1;
                first = 1'b0;
            end
            run_to_idle(1'b1);
        end

        // Widest period and repeat values written while idle; idle ticks change nothing.
        idling_on = 1'b0;
        write_reg(rspe_pkg::REG_PERIOD, 32'd4095);
        write_reg(rspe_pkg::REG_REPEAT, 32'd7);
        repeat (16) send_tick();

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Covered %0d accepted commands, commands dropped while busy and a long hold-off.",
                 commands_taken);
        $display("%0d output words compared; %0d active and %0d ignored input words.",
                 words_checked, live_items, ignored_items);
        if (error_count == 0)
            $display("remote_switch_pulse_encoder_core: match");
        else
            $display("remote_switch_pulse_encoder_core: mismatch");
        $finish;
    end

endmodule
